>>> src/tcw_pkg.sv
// Shared constants, types and helpers for the text console writer.
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);

   localparam int ACTION_W   = 2;
   localparam int CHAR_W     = 8;
   localparam int RROW_W     = 5;
   localparam int RCOL_W     = 7;
   localparam int CELL_W     = 16;
   localparam int COLOR_W    = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [ACTION_W-1:0] ACTION_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_READ  = 2'd2;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0720;
   localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;

   typedef enum logic [2:0] {
      OP_NOP     = 3'd0,
      OP_PUT     = 3'd1,
      OP_NEWLINE = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_READ    = 3'd4
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CHAR_W-1:0]     char_code;
      logic [ROW_W-1:0]      row;
      logic [COL_W-1:0]      col;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic [CELL_W-1:0] entry,
      input logic [RROW_W-1:0] row,
      input logic [RCOL_W-1:0] col,
      input logic              scr
   );
      return {3'b000, scr, col, row, entry};
   endfunction

endpackage

>>> src/tcw_front.sv
// Front end: accepts request words, decodes them and queues them for the back end.
module tcw_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // action[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zero pad
   input  logic [tcw_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  tcw_pkg::back_status_type              status,
   input  logic                                  pop,
   output tcw_pkg::head_type                     head
);

   tcw_pkg::item_type                q_ff [tcw_pkg::QDEPTH];
   logic [tcw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::QPTR_W:0]         cnt_ff, cnt_in;
   logic                             push;
   tcw_pkg::item_type                dec;

   logic [tcw_pkg::ACTION_W-1:0]     f_action;
   logic [tcw_pkg::CHAR_W-1:0]       f_char;
   logic [tcw_pkg::RROW_W-1:0]       f_row;
   logic [tcw_pkg::RCOL_W-1:0]       f_col;
   logic                             in_range;

   assign f_action = req_tdata[1:0];
   assign f_char   = req_tdata[9:2];
   assign f_row    = req_tdata[14:10];
   assign f_col    = req_tdata[21:15];
   assign in_range = (int'(f_row) < tcw_pkg::ROWS) && (int'(f_col) < tcw_pkg::COLUMNS);

   always_comb begin
      dec.char_code = f_char;
      dec.row       = (tcw_pkg::ROW_W)'(f_row);
      dec.col       = (tcw_pkg::COL_W)'(f_col);
      case (f_action)
         tcw_pkg::ACTION_PUT: begin
            dec.op = (f_char == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
         end
         tcw_pkg::ACTION_CLEAR: begin
            dec.op = tcw_pkg::OP_CLEAR;
         end
         tcw_pkg::ACTION_READ: begin
            dec.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
         end
         default: begin
            dec.op = tcw_pkg::OP_NOP;
         end
      endcase
   end

   assign req_tready = (int'(cnt_ff) != tcw_pkg::QDEPTH) && !status.init_busy;
   assign push       = req_tvalid && req_tready;

   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

>>> src/tcw_back.sv
// Back end: cell memory, cursor, scroll and clear row sweeps, result register.
module tcw_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [tcw_pkg::COLOR_W-1:0]           csr_wdata,
   input  tcw_pkg::head_type                     head,
   output logic                                  pop,
   output tcw_pkg::back_status_type              status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // cell_entry[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28], zero pad
   output logic [tcw_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [tcw_pkg::ROW_W-1:0]         row_ff, row_in;
   logic [tcw_pkg::COL_W-1:0]         col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]         top_ff, top_in;
   logic [tcw_pkg::COLOR_W-1:0]       color_ff, color_in;
   logic [tcw_pkg::ADDR_W-1:0]        sweep_addr_ff, sweep_addr_in;
   logic [tcw_pkg::ADDR_W-1:0]        sweep_last_ff, sweep_last_in;
   logic [tcw_pkg::CELL_W-1:0]        sweep_cell_ff, sweep_cell_in;
   logic                              init_ff, init_in;
   logic                              out_valid_ff, out_valid_in;
   logic [tcw_pkg::RSP_DATA_W-1:0]    out_data_ff, out_data_in;

   logic [tcw_pkg::CELL_W-1:0]        mem [tcw_pkg::CELL_COUNT];
   logic [tcw_pkg::CELL_W-1:0]        rd_data_ff;
   logic                              mem_we;
   logic [tcw_pkg::ADDR_W-1:0]        mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]        mem_wdata;
   logic [tcw_pkg::ADDR_W-1:0]        cur_addr;
   logic [tcw_pkg::ADDR_W-1:0]        rd_addr;
   logic [tcw_pkg::ADDR_W-1:0]        top_base;

   logic [tcw_pkg::CELL_W-1:0]        cell_v;
   logic [tcw_pkg::ROW_W-1:0]         nrow;
   logic [tcw_pkg::COL_W-1:0]         ncol;
   logic                              scr_v;
   logic                              nxt_line;
   logic [tcw_pkg::COL_W:0]           col_inc;

   // logical row plus top-of-screen offset, wrapped, times the line length
   function automatic logic [tcw_pkg::ADDR_W-1:0] cell_addr(
      input logic [tcw_pkg::ROW_W-1:0] row,
      input logic [tcw_pkg::COL_W-1:0] col,
      input logic [tcw_pkg::ROW_W-1:0] top
   );
      logic [tcw_pkg::ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (int'(sum) >= tcw_pkg::ROWS) begin
         sum = sum - (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS);
      end
      return (tcw_pkg::ADDR_W)'((tcw_pkg::ADDR_W)'(sum) * (tcw_pkg::ADDR_W)'(tcw_pkg::COLUMNS))
         + (tcw_pkg::ADDR_W)'(col);
   endfunction

   assign cur_addr = cell_addr(row_ff, col_ff, top_ff);
   assign rd_addr  = cell_addr(head.item.row, head.item.col, top_ff);
   assign top_base = (tcw_pkg::ADDR_W)'((tcw_pkg::ADDR_W)'(top_ff)
      * (tcw_pkg::ADDR_W)'(tcw_pkg::COLUMNS));
   assign col_inc  = {1'b0, col_ff} + 1'b1;

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_tdata        = out_data_ff;
   assign status.init_busy = init_ff;

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      top_in        = top_ff;
      color_in      = color_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      sweep_cell_in = sweep_cell_ff;
      init_in       = init_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_addr;
      mem_wdata     = {color_ff, head.item.char_code};
      pop           = 1'b0;
      cell_v        = '0;
      nrow          = row_ff;
      ncol          = col_ff;
      scr_v         = 1'b0;
      nxt_line      = 1'b0;

      if (csr_we) begin
         color_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head.valid && (!out_valid_ff || rsp_tready)) begin
               pop = 1'b1;
               case (head.item.op)
                  tcw_pkg::OP_PUT: begin
                     cell_v = {color_ff, head.item.char_code};
                     mem_we = 1'b1;
                     if (int'(col_inc) == tcw_pkg::COLUMNS) begin
                        nxt_line = 1'b1;
                     end else begin
                        ncol = col_inc[tcw_pkg::COL_W-1:0];
                     end
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     nxt_line = 1'b1;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     nrow          = '0;
                     ncol          = '0;
                     top_in        = '0;
                     sweep_addr_in = '0;
                     sweep_last_in = (tcw_pkg::ADDR_W)'(tcw_pkg::CELL_COUNT - 1);
                     sweep_cell_in = tcw_pkg::BLANK_CELL;
                     state_in      = ST_SWEEP;
                  end
                  tcw_pkg::OP_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
               if (nxt_line) begin
                  ncol = '0;
                  if (int'(row_ff) == tcw_pkg::ROWS - 1) begin
                     // old top line becomes the new bottom line, blanked in place
                     scr_v         = 1'b1;
                     top_in        = (int'(top_ff) == tcw_pkg::ROWS - 1) ? '0 : top_ff + 1'b1;
                     sweep_addr_in = top_base;
                     sweep_last_in = top_base + (tcw_pkg::ADDR_W)'(tcw_pkg::COLUMNS - 1);
                     sweep_cell_in = {color_ff, tcw_pkg::SPACE_CODE};
                     state_in      = ST_SWEEP;
                  end else begin
                     nrow = row_ff + 1'b1;
                  end
               end
               row_in = nrow;
               col_in = ncol;
               if (head.item.op != tcw_pkg::OP_READ) begin
                  out_valid_in = 1'b1;
                  out_data_in  = tcw_pkg::pack_rsp(cell_v, (tcw_pkg::RROW_W)'(nrow),
                     (tcw_pkg::RCOL_W)'(ncol), scr_v);
               end
            end
         end
         ST_READ: begin
            out_valid_in = 1'b1;
            out_data_in  = tcw_pkg::pack_rsp(rd_data_ff, (tcw_pkg::RROW_W)'(row_ff),
               (tcw_pkg::RCOL_W)'(col_ff), 1'b0);
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = sweep_cell_ff;
            if (sweep_addr_ff == sweep_last_ff) begin
               init_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_ff        <= '0;
         col_ff        <= '0;
         top_ff        <= '0;
         color_ff      <= tcw_pkg::COLOR_RESET;
         sweep_addr_ff <= '0;
         sweep_last_ff <= (tcw_pkg::ADDR_W)'(tcw_pkg::CELL_COUNT - 1);
         sweep_cell_ff <= tcw_pkg::BLANK_CELL;
         init_ff       <= 1'b1;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         top_ff        <= top_in;
         color_ff      <= color_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         sweep_cell_ff <= sweep_cell_in;
         init_ff       <= init_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> src/text_console_writer.sv
// Text console writer top level: front end, request queue and back end.
// Put, newline, clear and out-of-range read results pass the request queue and the result
// register; an in-range read also passes the registered cell memory read port.
// Throughput: one word per cycle through the back end while the result register drains
// and no sweep runs; a read holds it in its read state. A scroll blanks one line of
// COLUMNS cells; a clear rewrites ROWS*COLUMNS cells. Reset is synchronous: after it
// a pass blanks all 2000 cells with req_tready low; color returns to 7, cursor to home.
module text_console_writer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tcw_pkg::COLOR_W-1:0]        csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // action[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zero pad
   input  logic [tcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cell_entry[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28], zero pad
   output logic [tcw_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   tcw_pkg::head_type         head;
   tcw_pkg::back_status_type  status;
   logic                      pop;

   tcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .status     (status),
      .pop        (pop),
      .head       (head)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head       (head),
      .pop        (pop),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_no_accept_during_init: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !status.init_busy)
      else $error("word accepted during the reset clearing pass");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   a_scroll_homes_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[28]) |-> (rsp_tdata[27:21] == 7'd0))
      else $error("scroll reported with cursor column not at line start");
`endif

endmodule
